// ----- design/tdss_pkg.sv -----
package tdss_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 64;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned TAG_W = 2;
  localparam int unsigned OPCODE_W = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W = 7;

  // stack words
  localparam logic [OPCODE_W-1:0] OP_PUSH  = 5'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 5'd1;
  localparam logic [OPCODE_W-1:0] OP_DUP   = 5'd2;
  localparam logic [OPCODE_W-1:0] OP_DUPD  = 5'd3;
  localparam logic [OPCODE_W-1:0] OP_DUP2  = 5'd4;
  localparam logic [OPCODE_W-1:0] OP_SWAP  = 5'd5;
  localparam logic [OPCODE_W-1:0] OP_SWAPD = 5'd6;
  localparam logic [OPCODE_W-1:0] OP_SWAP2 = 5'd7;
  localparam logic [OPCODE_W-1:0] OP_OVER  = 5'd8;
  localparam logic [OPCODE_W-1:0] OP_OVERD = 5'd9;
  localparam logic [OPCODE_W-1:0] OP_OVER2 = 5'd10;
  localparam logic [OPCODE_W-1:0] OP_NIP   = 5'd11;
  localparam logic [OPCODE_W-1:0] OP_NIPD  = 5'd12;
  localparam logic [OPCODE_W-1:0] OP_DROP  = 5'd13;
  localparam logic [OPCODE_W-1:0] OP_DROP2 = 5'd14;
  localparam logic [OPCODE_W-1:0] OP_ROT   = 5'd15;
  localparam logic [OPCODE_W-1:0] OP_TUCK  = 5'd16;
  localparam logic [OPCODE_W-1:0] OP_PICK  = 5'd17;
  localparam logic [OPCODE_W-1:0] OP_ROLL  = 5'd18;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 5'd19;
  localparam logic [OPCODE_W-1:0] OP_DEPTH = 5'd20;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_INT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd5;

  localparam logic [TAG_W-1:0] TAG_INT = 2'd0;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } elem_t;

  // candidate next-content sources of a cell; the cells also load from up4 and pick_elem
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_UP1,
    SEL_UP2,
    SEL_UP3,
    SEL_DN1,
    SEL_DN2,
    SEL_NEW
  } sel_t;

  // row-wide command from the controller, decoded per cell
  typedef struct packed {
    logic        enable;
    logic [3:0]  mode;
    elem_t       new_elem;
  } row_cmd_t;

  // per-cell modes; cells compare their position against the fill level
  localparam logic [3:0] MD_NONE  = 4'd0;
  localparam logic [3:0] MD_PUSH  = 4'd1;  // top+1 <= new
  localparam logic [3:0] MD_COPY1 = 4'd2;  // generic: uses position table
  localparam logic [3:0] MD_ROLL  = 4'd3;
  localparam logic [3:0] MD_PICK  = 4'd4;

  // depth-relative slot mapping for shuffle words: for slot k from top (k = -2..3,
  // encoded k+2) give distance to source slot (negative = further below)
  function automatic logic [3:0] src_rel(input logic [OPCODE_W-1:0] op,
                                         input logic [2:0] k);
    // return value: {valid, signed 3-bit offset in src index relative to this slot}
    logic [3:0] r;
    r = 4'b0000;
    case (op)
      OP_DUP:   if (k == 3'd1) r = 4'b1111;                  // s <- t0
      OP_DUPD:  begin
        if (k == 3'd1) r = 4'b1111;                          // s <- t0
        if (k == 3'd2) r = 4'b1111;                          // t0 <- t0-1
      end
      OP_DUP2:  if (k == 3'd1 || k == 3'd0) r = 4'b1110;     // s<-t0-1, s+1<-t0
      OP_SWAP:  begin
        if (k == 3'd2) r = 4'b1111;
        if (k == 3'd3) r = 4'b1001;
      end
      OP_SWAPD: begin
        if (k == 3'd3) r = 4'b1111;
        if (k == 3'd4) r = 4'b1001;
      end
      OP_SWAP2: begin
        if (k == 3'd2 || k == 3'd3) r = 4'b1110;
        if (k == 3'd4 || k == 3'd5) r = 4'b1010;
      end
      OP_OVER:  if (k == 3'd1) r = 4'b1110;
      OP_OVERD: begin
        if (k == 3'd1) r = 4'b1111;
        if (k == 3'd2) r = 4'b1110;
      end
      OP_OVER2: if (k == 3'd1 || k == 3'd0) r = 4'b1100;
      OP_NIP, OP_NIPD: if (k == 3'd3) r = 4'b1001;
      OP_ROT:   begin
        if (k == 3'd2) r = 4'b1110;
        if (k == 3'd3 || k == 3'd4) r = 4'b1001;
      end
      OP_TUCK:  begin
        if (k == 3'd1) r = 4'b1111;
        if (k == 3'd2) r = 4'b1111;
        if (k == 3'd3) r = 4'b1001;
      end
      default:  r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

// ----- design/tdss_cell.sv -----
module tdss_cell #(
  parameter int unsigned STACK_DEPTH = tdss_pkg::DEFAULT_STACK_DEPTH,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned POS = 0
) (
  input  logic             clk,
  input  tdss_pkg::row_cmd_t cmd,
  input  logic [IDX_W:0]   fill,
  input  logic [IDX_W:0]   roll_src,
  input  tdss_pkg::elem_t  up1,
  input  tdss_pkg::elem_t  up2,
  input  tdss_pkg::elem_t  up3,
  input  tdss_pkg::elem_t  up4,
  input  tdss_pkg::elem_t  dn1,
  input  tdss_pkg::elem_t  dn2,
  input  tdss_pkg::elem_t  pick_elem,
  input  logic [tdss_pkg::OPCODE_W-1:0] op,
  output tdss_pkg::elem_t  q
);
  import tdss_pkg::*;

  localparam logic [IDX_W:0] MY_POS = (IDX_W+1)'(POS);

  elem_t q_r;
  elem_t q_nxt;
  logic [IDX_W:0] k_full;
  logic [3:0] rel;

  assign q = q_r;

  // slots below the top plus two: top slot is 2, first free slot 1, window 0..5
  always_comb begin
    k_full = fill - MY_POS + (IDX_W+1)'(1);
    rel = 4'b0000;
    if (k_full <= (IDX_W+1)'(5)) begin
      rel = src_rel(op, k_full[2:0]);
    end
  end

  // choose this cell's next content; pick_elem also carries the roll source
  always_comb begin
    q_nxt = q_r;
    if (cmd.enable) begin
      case (cmd.mode)
        MD_PUSH: if (fill == MY_POS) q_nxt = cmd.new_elem;
        MD_PICK: if (fill == MY_POS + (IDX_W+1)'(1)) q_nxt = pick_elem;
        MD_ROLL: begin
          if (MY_POS + (IDX_W+1)'(2) == fill) q_nxt = pick_elem;
          else if (MY_POS >= roll_src && MY_POS + (IDX_W+1)'(2) < fill) q_nxt = dn1;
        end
        MD_COPY1: begin
          if (rel[3]) begin
            case (rel[2:0])
              3'b111: q_nxt = up1;
              3'b110: q_nxt = up2;
              3'b101: q_nxt = up3;
              3'b100: q_nxt = up4;
              3'b001: q_nxt = dn1;
              3'b010: q_nxt = dn2;
              default: q_nxt = q_r;
            endcase
          end
        end
        default: q_nxt = q_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ----- design/tagged_data_stack_shuffle_unit.sv -----
// Tagged data stack: a row of STACK_DEPTH cells, cell i holding stack slot i
// (slot 0 at the bottom). Every stack word, roll included, updates all cells in
// the cycle it is accepted: each cell loads from itself, a neighbor up to four
// slots away, the request's push element, or the element that pick or roll
// reads through a depth-wide select. The result (status, new top or popped
// element, depth) is built from the updated cells into an output register,
// so out_valid rises after the cells update, and no new request is accepted
// while a result is still being built or waits on out_ready. No clearing
// pass is needed after reset.
module tagged_data_stack_shuffle_unit #(
  parameter int unsigned STACK_DEPTH = tdss_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tdss_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic signed [tdss_pkg::VALUE_W-1:0] in_push_value,
  input  logic [tdss_pkg::TAG_W-1:0]        in_push_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdss_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_result_valid,
  output logic signed [tdss_pkg::VALUE_W-1:0] out_result_value,
  output logic [tdss_pkg::TAG_W-1:0]        out_result_tag,
  output logic [tdss_pkg::COUNT_W-1:0]      out_stack_count
);
  import tdss_pkg::*;

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam logic [IDX_W:0] DEPTH_C = (IDX_W+1)'(STACK_DEPTH);

  logic [IDX_W:0] fill_r, fill_nxt;
  logic           pend_r;        // result loaded into cells, not yet shown
  logic           pop_r;
  elem_t          pop_elem_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic           out_valid_r;
  logic [STATUS_W-1:0] o_status_r;
  logic           o_rv_r;
  elem_t          o_elem_r;
  logic [COUNT_W-1:0] o_cnt_r;

  elem_t cells [STACK_DEPTH];
  row_cmd_t cmd;
  logic [IDX_W:0] roll_src;
  elem_t top_e, pick_e;
  logic [3:0] need, grow;
  logic accept;
  logic [VALUE_W-1:0] idx_v;

  // result goes out the cycle after the cells update; pend holds that slot
  assign in_ready = !pend_r && (!out_valid_r || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    top_e = '0;
    if (fill_r != '0) top_e = cells[IDX_W'(fill_r - (IDX_W+1)'(1))];
  end
  assign idx_v = top_e.value;

  // requirements per word
  always_comb begin
    need = 4'd0;
    grow = 4'd0;
    case (in_opcode)
      OP_PUSH: grow = 4'd1;
      OP_POP, OP_DROP, OP_PICK, OP_ROLL: need = 4'd1;
      OP_DUP: begin need = 4'd1; grow = 4'd1; end
      OP_DUPD, OP_OVER, OP_TUCK: begin need = 4'd2; grow = 4'd1; end
      OP_DUP2: begin need = 4'd2; grow = 4'd2; end
      OP_SWAP, OP_NIP, OP_DROP2: need = 4'd2;
      OP_SWAPD, OP_NIPD, OP_ROT: need = 4'd3;
      OP_OVERD: begin need = 4'd3; grow = 4'd1; end
      OP_SWAP2: need = 4'd4;
      OP_OVER2: begin need = 4'd4; grow = 4'd2; end
      OP_DEPTH: grow = 4'd1;
      default: begin need = 4'd0; grow = 4'd0; end
    endcase
  end

  // decode word into a row command and next fill level
  always_comb begin
    logic [IDX_W:0] m;
    logic [IDX_W:0] pick_i;
    m = fill_r - (IDX_W+1)'(1);
    pick_i = '0;
    status_nxt = ST_OK;
    fill_nxt = fill_r;
    roll_src = '0;
    cmd.enable = 1'b0;
    cmd.mode = MD_NONE;
    cmd.new_elem.value = in_push_value;
    cmd.new_elem.tag = in_push_tag;
    if (in_opcode > OP_DEPTH) begin
      status_nxt = ST_OK;
    end else if ((IDX_W+1)'(need) > fill_r) begin
      status_nxt = ST_UNDERFLOW;
    end else if ((IDX_W+2)'(fill_r) + (IDX_W+2)'(grow) > (IDX_W+2)'(DEPTH_C)) begin
      status_nxt = ST_OVERFLOW;
    end else begin
      cmd.enable = 1'b1;
      case (in_opcode)
        OP_PUSH: begin cmd.mode = MD_PUSH; fill_nxt = fill_r + (IDX_W+1)'(1); end
        OP_DEPTH: begin
          cmd.mode = MD_PUSH;
          cmd.new_elem.value = VALUE_W'(fill_r);
          cmd.new_elem.tag = TAG_INT;
          fill_nxt = fill_r + (IDX_W+1)'(1);
        end
        OP_POP, OP_DROP: fill_nxt = m;
        OP_DROP2: fill_nxt = fill_r - (IDX_W+1)'(2);
        OP_CLEAR: fill_nxt = '0;
        OP_PICK, OP_ROLL: begin
          if (top_e.tag != TAG_INT) status_nxt = ST_NOT_INT;
          else if (idx_v[VALUE_W-1]) status_nxt = ST_NEGATIVE;
          else if (in_opcode == OP_PICK) begin
            if (idx_v >= VALUE_W'(m)) status_nxt = ST_RANGE;
            else cmd.mode = MD_PICK;
          end else if (idx_v > VALUE_W'(m)) status_nxt = ST_RANGE;
          else begin
            fill_nxt = m;
            roll_src = m - (IDX_W+1)'(idx_v[IDX_W:0]);
            if (idx_v != '0) cmd.mode = MD_ROLL;
          end
          if (status_nxt != ST_OK) cmd.enable = 1'b0;
        end
        default: begin
          cmd.mode = MD_COPY1;
          if (in_opcode == OP_DUP || in_opcode == OP_DUPD || in_opcode == OP_OVER ||
              in_opcode == OP_OVERD || in_opcode == OP_TUCK)
            fill_nxt = fill_r + (IDX_W+1)'(1);
          else if (in_opcode == OP_DUP2 || in_opcode == OP_OVER2)
            fill_nxt = fill_r + (IDX_W+1)'(2);
          else if (in_opcode == OP_NIP || in_opcode == OP_NIPD)
            fill_nxt = m;
        end
      endcase
    end
    if (!accept) cmd.enable = 1'b0;
    // roll moves slot m-n to the top; pick copies the slot one below that
    pick_i = m - (IDX_W+1)'(idx_v[IDX_W:0]);
    if (in_opcode != OP_ROLL) pick_i = pick_i - (IDX_W+1)'(1);
    pick_e = cells[IDX_W'(pick_i)];
  end

  // row of cells; shuffle words see the fill level before the step
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    elem_t u1, u2, d1, d2, d3, d4;
    assign u1 = (i + 1 < STACK_DEPTH) ? cells[(i + 1) % STACK_DEPTH] : '0;
    assign u2 = (i + 2 < STACK_DEPTH) ? cells[(i + 2) % STACK_DEPTH] : '0;
    assign d1 = (i >= 1) ? cells[(i + STACK_DEPTH - 1) % STACK_DEPTH] : '0;
    assign d2 = (i >= 2) ? cells[(i + STACK_DEPTH - 2) % STACK_DEPTH] : '0;
    assign d3 = (i >= 3) ? cells[(i + STACK_DEPTH - 3) % STACK_DEPTH] : '0;
    assign d4 = (i >= 4) ? cells[(i + STACK_DEPTH - 4) % STACK_DEPTH] : '0;
    tdss_cell #(
      .STACK_DEPTH(STACK_DEPTH),
      .IDX_W(IDX_W),
      .POS(i)
    ) u_cell (
      .clk(clk),
      .cmd(cmd),
      .fill(fill_r),
      .roll_src(roll_src),
      .up1(d1),
      .up2(d2),
      .up3(d3),
      .up4(d4),
      .dn1(u1),
      .dn2(u2),
      .pick_elem(pick_e),
      .op(in_opcode),
      .q(cells[i])
    );
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
        status_r <= status_nxt;
        pop_r <= (in_opcode == OP_POP) && cmd.enable;
        pop_elem_r <= top_e;
      end
      pend_r <= accept;
      if (pend_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (pend_r) begin
        o_status_r <= status_r;
        o_cnt_r <= COUNT_W'(fill_r);
        if (pop_r) begin
          o_rv_r <= 1'b1;
          o_elem_r <= pop_elem_r;
        end else begin
          o_rv_r <= (fill_r != '0);
          o_elem_r <= (fill_r != '0) ? top_e : '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = o_status_r;
  assign out_result_valid = o_rv_r;
  assign out_result_value = o_elem_r.value;
  assign out_result_tag = o_elem_r.tag;
  assign out_stack_count = o_cnt_r;

endmodule

// ----- design/tdss_checker.sv -----
module tdss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_result_valid,
  input logic [6:0] out_stack_count
);
  // an error result with an empty stack carries no element
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stack_count == 7'd0 && out_status != 3'd0 |-> !out_result_valid)
    else $error("element reported on empty stack after error");

  // a result follows each accepted request
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("missing result");

  // status within code range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd5)
    else $error("bad status");

  // held result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
endmodule

bind tagged_data_stack_shuffle_unit tdss_checker u_tdss_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_result_valid(out_result_valid), .out_stack_count(out_stack_count)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import tdss_pkg::*;

  localparam int DEPTH = 64;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [63:0] value;
    logic [1:0]  tag;
  } stack_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        has_elem;
    logic [63:0] value;
    logic [1:0]  tag;
    logic [6:0]  count;
  } stack_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_opcode = '0;
  logic signed [63:0] in_push_value = '0;
  logic [1:0]  in_push_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_result_valid;
  logic signed [63:0] out_result_value;
  logic [1:0]  out_result_tag;
  logic [6:0]  out_stack_count;

  tagged_data_stack_shuffle_unit dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [63:0] shadow_val [DEPTH];
  logic [1:0]  shadow_tag [DEPTH];
  int          shadow_fill = 0;

  stack_req_t  pending_reqs [$];
  stack_resp_t expected_resps [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_send = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic int need_of(input logic [4:0] op);
    case (op)
      OP_PUSH, OP_CLEAR, OP_DEPTH: return 0;
      OP_POP, OP_DUP, OP_DROP, OP_PICK, OP_ROLL: return 1;
      OP_DUPD, OP_DUP2, OP_SWAP, OP_OVER, OP_NIP, OP_DROP2, OP_TUCK: return 2;
      OP_SWAPD, OP_OVERD, OP_NIPD, OP_ROT: return 3;
      OP_SWAP2, OP_OVER2: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int grow_of(input logic [4:0] op);
    case (op)
      OP_PUSH, OP_DUP, OP_DUPD, OP_OVER, OP_OVERD, OP_TUCK, OP_DEPTH: return 1;
      OP_DUP2, OP_OVER2: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic void slot_copy(input int d, input int s);
    shadow_val[d] = shadow_val[s];
    shadow_tag[d] = shadow_tag[s];
  endfunction

  function automatic void slot_swap(input int i, input int j);
    logic [63:0] v;
    logic [1:0]  t;
    v = shadow_val[i];
    t = shadow_tag[i];
    slot_copy(i, j);
    shadow_val[j] = v;
    shadow_tag[j] = t;
  endfunction

  // apply one stack word to the shadow stack, return the expected response
  function automatic stack_resp_t apply_word(input stack_req_t r);
    stack_resp_t o;
    int s, t0, m, src;
    logic [63:0] n;
    bit popped;
    o = '0;
    popped = 0;
    s = shadow_fill;
    t0 = s - 1;
    if (r.opcode <= OP_DEPTH) begin
      if (s < need_of(r.opcode)) o.status = ST_UNDERFLOW;
      else if (s + grow_of(r.opcode) > DEPTH) o.status = ST_OVERFLOW;
      else begin
        case (r.opcode)
          OP_PUSH: begin
            shadow_val[s] = r.value;
            shadow_tag[s] = r.tag;
            s++;
          end
          OP_POP: begin
            o.value = shadow_val[t0];
            o.tag = shadow_tag[t0];
            popped = 1;
            s--;
          end
          OP_DUP: begin slot_copy(s, t0); s++; end
          OP_DUPD: begin slot_copy(s, t0); slot_copy(t0, t0 - 1); s++; end
          OP_DUP2: begin slot_copy(s, t0 - 1); slot_copy(s + 1, t0); s += 2; end
          OP_SWAP: slot_swap(t0, t0 - 1);
          OP_SWAPD: slot_swap(t0 - 1, t0 - 2);
          OP_SWAP2: begin slot_swap(t0, t0 - 2); slot_swap(t0 - 1, t0 - 3); end
          OP_OVER: begin slot_copy(s, t0 - 1); s++; end
          OP_OVERD: begin slot_copy(s, t0); slot_copy(t0, t0 - 2); s++; end
          OP_OVER2: begin slot_copy(s, t0 - 3); slot_copy(s + 1, t0 - 2); s += 2; end
          OP_NIP, OP_NIPD: begin slot_copy(t0 - 1, t0); s--; end
          OP_DROP: s--;
          OP_DROP2: s -= 2;
          OP_ROT: begin slot_swap(t0 - 2, t0 - 1); slot_swap(t0 - 1, t0); end
          OP_TUCK: begin slot_copy(s, t0); slot_swap(t0, t0 - 1); s++; end
          OP_PICK, OP_ROLL: begin
            n = shadow_val[t0];
            m = t0;
            if (shadow_tag[t0] != TAG_INT) o.status = ST_NOT_INT;
            else if (n[63]) o.status = ST_NEGATIVE;
            else if (r.opcode == OP_PICK) begin
              if (n >= 64'(m)) o.status = ST_RANGE;
              else slot_copy(t0, m - 1 - int'(n));
            end else if (n > 64'(m)) o.status = ST_RANGE;
            else begin
              if (n != 0) begin
                src = m - int'(n);
                for (int i = src; i + 1 < m; i++) slot_swap(i, i + 1);
              end
              s = m;
            end
          end
          OP_CLEAR: s = 0;
          OP_DEPTH: begin
            shadow_val[s] = 64'(s);
            shadow_tag[s] = TAG_INT;
            s++;
          end
          default: ;
        endcase
      end
    end
    shadow_fill = s;
    if (popped) o.has_elem = 1'b1;
    else if (s > 0) begin
      o.has_elem = 1'b1;
      o.value = shadow_val[s - 1];
      o.tag = shadow_tag[s - 1];
    end
    o.count = 7'(s);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          stack_req_t r;
          r = pending_reqs.pop_front();
          expected_resps.push_back(apply_word(r));
          in_valid <= 1'b1;
          in_opcode <= r.opcode;
          in_push_value <= r.value;
          in_push_tag <= r.tag;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) report("response with no request pending");
      else begin
        stack_resp_t e;
        e = expected_resps.pop_front();
        if (out_status !== e.status)
          report($sformatf("status got %0d want %0d", out_status, e.status));
        if (out_result_valid !== e.has_elem)
          report($sformatf("result_valid got %0b want %0b", out_result_valid, e.has_elem));
        if (out_result_value !== e.value)
          report($sformatf("value got %h want %h", out_result_value, e.value));
        if (out_result_tag !== e.tag)
          report($sformatf("tag got %0d want %0d", out_result_tag, e.tag));
        if (out_stack_count !== e.count)
          report($sformatf("count got %0d want %0d", out_stack_count, e.count));
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void add_req(input logic [4:0] op, input logic [63:0] v,
                                  input logic [1:0] t);
    stack_req_t r;
    r.opcode = op;
    r.value = v;
    r.tag = t;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_index();
    case ($urandom_range(9, 0))
      0: return rand64();
      1: return {1'b1, 63'($urandom())};
      2: return 64'($urandom_range(70, 0));
      default: return 64'($urandom_range(6, 0));
    endcase
  endfunction

  // random stack words, mostly well formed with occasional index pushes
  function automatic void add_random(input int count);
    for (int i = 0; i < count; i++) begin
      int k;
      k = $urandom_range(99, 0);
      if (k < 30) add_req(OP_PUSH, rand64(), 2'($urandom()));
      else if (k < 40) begin
        add_req(OP_PUSH, rand_index(), ($urandom_range(5, 0) == 0) ? 2'($urandom()) : TAG_INT);
        add_req(($urandom_range(1, 0) == 1) ? OP_PICK : OP_ROLL, rand64(), 2'($urandom()));
        i++;
      end else if (k < 42) add_req(OP_CLEAR, rand64(), 2'($urandom()));
      else if (k < 45) add_req(5'($urandom_range(31, 21)), rand64(), 2'($urandom()));
      else if (k < 55) add_req(OP_POP, rand64(), 2'($urandom()));
      else add_req(5'($urandom_range(20, 1)), rand64(), 2'($urandom()));
    end
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: underflow on empty, extremes, each word, index errors
    add_req(OP_POP, '0, 2'd0);
    add_req(OP_PICK, '0, 2'd0);
    add_req(OP_PUSH, 64'h8000_0000_0000_0000, 2'd3);
    add_req(OP_PUSH, 64'h7fff_ffff_ffff_ffff, 2'd2);
    add_req(OP_PUSH, '1, 2'd1);
    add_req(OP_PUSH, 64'd0, 2'd0);
    for (logic [4:0] op = OP_DUP; op <= OP_TUCK; op++) add_req(op, '0, 2'd0);
    add_req(OP_DEPTH, '0, 2'd0);
    add_req(OP_PUSH, 64'd1, 2'd1);
    add_req(OP_PICK, '0, 2'd0);
    add_req(OP_PUSH, '1, 2'd0);
    add_req(OP_ROLL, '0, 2'd0);
    add_req(OP_PUSH, 64'd200, 2'd0);
    add_req(OP_PICK, '0, 2'd0);
    add_req(5'd31, '0, 2'd0);
    add_req(OP_CLEAR, '0, 2'd0);
    drain();

    // fill to overflow, then roll across the full stack
    for (int i = 0; i < 65; i++) add_req(OP_PUSH, rand64(), 2'($urandom()));
    add_req(OP_DUP2, '0, 2'd0);
    add_req(OP_POP, '0, 2'd0);
    add_req(OP_PUSH, 64'd63, 2'd0);
    add_req(OP_ROLL, '0, 2'd0);
    add_req(OP_PUSH, 64'd62, 2'd0);
    add_req(OP_PICK, '0, 2'd0);
    add_req(OP_CLEAR, '0, 2'd0);
    drain();

    // random phases with differing idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 29) : 0;
      recv_stall_pct = (ph == 2) ? 86 : (ph == 3 ? 29 : 0);
      add_random(300);
      if (ph == 0) begin
        while (pending_reqs.size() > 150) @(posedge clk);
        hold_send = 1'b1;
        while (expected_resps.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
design/tdss_pkg.sv
design/tdss_cell.sv
design/tagged_data_stack_shuffle_unit.sv
design/tdss_checker.sv
tb/tb.sv
